// ===== design/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA truecolor decoder package
// Shared types and codes for the byte-stream TGA decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

	// Parser phases.
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_SKIP   = 2'd1;
	localparam logic [1:0] PH_PIXELS = 2'd2;
	localparam logic [1:0] PH_IDLE   = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_PIXEL  = 2'd2;

	// Header byte positions that carry information.
	localparam logic [4:0] HDR_ID_LEN     = 5'd0;
	localparam logic [4:0] HDR_MAP_TYPE   = 5'd1;
	localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
	localparam logic [4:0] HDR_PIXEL_BITS = 5'd16;
	localparam logic [4:0] HDR_LAST       = 5'd17;

	// Byte positions within a pixel (BGR or BGRA order in the file).
	localparam logic [1:0] PIX_BLUE  = 2'd0;
	localparam logic [1:0] PIX_GREEN = 2'd1;
	localparam logic [1:0] PIX_RED   = 2'd2;
	localparam logic [1:0] PIX_ALPHA = 2'd3;

	// Accepted format.
	localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] MAP_NONE       = 8'd0;
	localparam logic [7:0] BITS_24        = 8'd24;
	localparam logic [7:0] BITS_32        = 8'd32;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

	// One input transaction.
	typedef struct packed {
		logic [7:0] file_byte;
		logic       start_of_file;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last;
	} result_t;

endpackage

// ===== design/tgad_in_stage.sv =====
// ----------------------------------------------------------------------------
// TGA decoder input stage
// Registers one input transaction and frees itself when the parser takes it.
// ----------------------------------------------------------------------------
module tgad_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          file_byte,
	input  logic                start_of_file,
	input  logic                take,
	output logic                item_valid_s1,
	output tgad_pkg::in_item_t  item_s1
);

	// The stage can accept when empty or when its item leaves this cycle.
	assign in_ready = !item_valid_s1 || take;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			item_valid_s1 <= 1'b1;
		end else if (take) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.file_byte     <= file_byte;
			item_s1.start_of_file <= start_of_file;
		end
	end

endmodule

// ===== design/tgad_parser.sv =====
// ----------------------------------------------------------------------------
// TGA decoder parser
// Header collection, id field skip and pixel assembly for one byte per cycle while take is high.
// ----------------------------------------------------------------------------
module tgad_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  tgad_pkg::in_item_t  item_s1,
	output logic                res_valid,
	output tgad_pkg::result_t   res
);

	logic [1:0]  phase_q, phase_n;
	logic [4:0]  hdr_idx_q, hdr_idx_n;
	logic [7:0]  id_len_q, id_len_n;
	logic [7:0]  map_type_q, map_type_n;
	logic [7:0]  image_type_q, image_type_n;
	logic [7:0]  pixel_bits_q, pixel_bits_n;
	logic [15:0] width_q, width_n;
	logic [15:0] height_q, height_n;
	logic [7:0]  skip_q, skip_n;
	logic [31:0] pixels_q, pixels_n;
	logic [1:0]  pix_byte_q, pix_byte_n;
	logic [7:0]  blue_q, blue_n;
	logic [7:0]  green_q, green_n;
	logic [7:0]  red_q, red_n;
	logic [1:0]  cur_phase;
	logic [4:0]  cur_idx;
	logic [7:0]  b;
	logic [31:0] area;
	logic        empty_image;
	logic        bad_format;

	assign b           = item_s1.file_byte;
	assign area        = width_q * height_q;
	assign empty_image = (width_q == 16'd0) || (height_q == 16'd0);
	assign bad_format  = (image_type_q != tgad_pkg::TYPE_TRUECOLOR) ||
		(map_type_q != tgad_pkg::MAP_NONE) ||
		((pixel_bits_q != tgad_pkg::BITS_24) && (pixel_bits_q != tgad_pkg::BITS_32));

	// A start flag restarts header collection with this byte.
	assign cur_phase = item_s1.start_of_file ? tgad_pkg::PH_HEADER : phase_q;
	assign cur_idx   = item_s1.start_of_file ? 5'd0 : hdr_idx_q;

	// Next state and result for the byte in the input register.
	always_comb begin
		phase_n      = cur_phase;
		hdr_idx_n    = cur_idx;
		id_len_n     = id_len_q;
		map_type_n   = map_type_q;
		image_type_n = image_type_q;
		pixel_bits_n = pixel_bits_q;
		width_n      = width_q;
		height_n     = height_q;
		skip_n       = skip_q;
		pixels_n     = pixels_q;
		pix_byte_n   = pix_byte_q;
		blue_n       = blue_q;
		green_n      = green_q;
		red_n        = red_q;
		res_valid    = 1'b0;
		res          = '0;

		case (cur_phase)
			tgad_pkg::PH_HEADER: begin
				case (cur_idx)
					tgad_pkg::HDR_ID_LEN:     id_len_n = b;
					tgad_pkg::HDR_MAP_TYPE:   map_type_n = b;
					tgad_pkg::HDR_IMAGE_TYPE: image_type_n = b;
					tgad_pkg::HDR_WIDTH_LO:   width_n = {width_q[15:8], b};
					tgad_pkg::HDR_WIDTH_HI:   width_n = {b, width_q[7:0]};
					tgad_pkg::HDR_HEIGHT_LO:  height_n = {height_q[15:8], b};
					tgad_pkg::HDR_HEIGHT_HI:  height_n = {b, height_q[7:0]};
					tgad_pkg::HDR_PIXEL_BITS: pixel_bits_n = b;
					default: ;
				endcase
				if (cur_idx < tgad_pkg::HDR_LAST) begin
					hdr_idx_n = 5'(cur_idx + 5'd1);
				end else begin
					// Final header byte: decide on the format.
					hdr_idx_n              = 5'd0;
					res_valid              = 1'b1;
					res.image_width        = width_q;
					res.image_height       = height_q;
					if (bad_format) begin
						phase_n  = tgad_pkg::PH_IDLE;
						res.kind = tgad_pkg::KIND_REJECT;
					end else begin
						res.kind = tgad_pkg::KIND_ACCEPT;
						res.last = empty_image;
						pixels_n = area;
						if (empty_image) begin
							phase_n = tgad_pkg::PH_IDLE;
						end else if (id_len_q != 8'd0) begin
							skip_n  = id_len_q;
							phase_n = tgad_pkg::PH_SKIP;
						end else begin
							pix_byte_n = tgad_pkg::PIX_BLUE;
							phase_n    = tgad_pkg::PH_PIXELS;
						end
					end
				end
			end

			tgad_pkg::PH_SKIP: begin
				skip_n = 8'(skip_q - 8'd1);
				if (skip_n == 8'd0) begin
					pix_byte_n = tgad_pkg::PIX_BLUE;
					phase_n    = (pixels_q == 32'd0) ? tgad_pkg::PH_IDLE : tgad_pkg::PH_PIXELS;
				end
			end

			tgad_pkg::PH_PIXELS: begin
				// Collect color bytes; a pixel completes on red for 24-bit
				// data and on alpha for 32-bit data.
				res.kind  = tgad_pkg::KIND_PIXEL;
				res.blue  = blue_q;
				res.green = green_q;
				res.red   = red_q;
				res.alpha = b;
				res.last  = (pixels_q == 32'd1);
				case (pix_byte_q)
					tgad_pkg::PIX_BLUE:  blue_n = b;
					tgad_pkg::PIX_GREEN: green_n = b;
					tgad_pkg::PIX_RED: begin
						red_n = b;
						if (pixel_bits_q != tgad_pkg::BITS_32) begin
							res_valid = 1'b1;
							res.red   = b;
							res.alpha = tgad_pkg::ALPHA_OPAQUE;
						end
					end
					default: res_valid = 1'b1;
				endcase
				if (res_valid) begin
					pix_byte_n = tgad_pkg::PIX_BLUE;
					pixels_n   = 32'(pixels_q - 32'd1);
					if (pixels_q == 32'd1) begin
						phase_n = tgad_pkg::PH_IDLE;
					end
				end else begin
					pix_byte_n = 2'(pix_byte_q + 2'd1);
				end
			end

			default: ;
		endcase
	end

	// State registers, updated once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= tgad_pkg::PH_HEADER;
			hdr_idx_q    <= 5'd0;
			id_len_q     <= 8'd0;
			map_type_q   <= 8'd0;
			image_type_q <= 8'd0;
			pixel_bits_q <= 8'd0;
			width_q      <= 16'd0;
			height_q     <= 16'd0;
			skip_q       <= 8'd0;
			pixels_q     <= 32'd0;
			pix_byte_q   <= tgad_pkg::PIX_BLUE;
		end else if (take) begin
			phase_q      <= phase_n;
			hdr_idx_q    <= hdr_idx_n;
			id_len_q     <= id_len_n;
			map_type_q   <= map_type_n;
			image_type_q <= image_type_n;
			pixel_bits_q <= pixel_bits_n;
			width_q      <= width_n;
			height_q     <= height_n;
			skip_q       <= skip_n;
			pixels_q     <= pixels_n;
			pix_byte_q   <= pix_byte_n;
		end
	end

	// Partial pixel bytes.
	always_ff @(posedge clk) begin
		if (take) begin
			blue_q  <= blue_n;
			green_q <= green_n;
			red_q   <= red_n;
		end
	end

endmodule

// ===== design/tgad_out_stage.sv =====
// ----------------------------------------------------------------------------
// TGA decoder output stage
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module tgad_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  tgad_pkg::result_t  res,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         alpha,
	output logic [15:0]        image_width,
	output logic [15:0]        image_height,
	output logic               last
);

	tgad_pkg::result_t res_q;

	// A new result fits when the register is empty or drains this cycle.
	assign space = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign kind         = res_q.kind;
	assign red          = res_q.red;
	assign green        = res_q.green;
	assign blue         = res_q.blue;
	assign alpha        = res_q.alpha;
	assign image_width  = res_q.image_width;
	assign image_height = res_q.image_height;
	assign last         = res_q.last;

endmodule

// ===== design/tga_truecolor_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// TGA truecolor stream decoder
// Parses an uncompressed 24/32-bit TGA byte stream into header and RGBA pixel results.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per cycle, sustained, for as long as the
// result side keeps up. Each byte passes an input register and is parsed from
// there once the output side has room; a result, when the byte causes one, is
// loaded into the output register and offered from it in the cycle after the
// parse. The only thing that slows intake is back-pressure on the result
// channel: the parser advances whenever the output register is empty or being
// drained. Header results carry the image size; for an accepted header the
// pixel count is formed by one 16x16 multiplier on the final header byte.
module tga_truecolor_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  file_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        last
);

	logic               item_valid_s1;
	tgad_pkg::in_item_t item_s1;
	logic               take;
	logic               space;
	logic               res_valid;
	tgad_pkg::result_t  res;

	// The parser consumes the registered byte when the output side has room.
	assign take = item_valid_s1 && space;

	tgad_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.file_byte     (file_byte),
		.start_of_file (start_of_file),
		.take          (take),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	tgad_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	tgad_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take && res_valid),
		.res          (res),
		.space        (space),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.image_width  (image_width),
		.image_height (image_height),
		.last         (last)
	);

endmodule

// ===== design/tgad_checker.sv =====
// ----------------------------------------------------------------------------
// TGA decoder port checker
// Concurrent checks on the decoder's ports, bound to the top level.
// ----------------------------------------------------------------------------
module tgad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [7:0]  alpha,
	input logic [15:0] image_width,
	input logic [15:0] image_height,
	input logic        last
);

	// A stalled result transaction stays offered with its kind, color and last flag unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(red) &&
		$stable(green) && $stable(blue) && $stable(alpha) && $stable(last))
	else $error("stalled result changed");

	// Header results carry no color.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != tgad_pkg::KIND_PIXEL |->
		red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0)
	else $error("header result with pixel data");

	// Pixel results carry no size.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tgad_pkg::KIND_PIXEL |->
		image_width == 16'd0 && image_height == 16'd0)
	else $error("pixel result with size data");

	// A reject never marks the end of an image.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tgad_pkg::KIND_REJECT |-> !last)
	else $error("reject result flagged last");

endmodule

bind tga_truecolor_stream_decoder tgad_checker u_checker (.*);
